// File: hdl/tss_pkg.sv
// ----------------------------------------------------------------------------
// Temporal subsampling package
// Widths, register indexes, operation codes and the structs shared between
// the top level and the multiply-round unit.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int NUM_CH     = 256;  // channels addressable by the 8-bit field
  localparam int CH_W       = 8;
  localparam int SAMP_W     = 16;
  localparam int COEF_W     = 16;
  localparam int SUM_W      = 22;
  localparam int SUM_EXT_W  = SUM_W - SAMP_W;
  localparam int FRAME_W    = 16;
  localparam int VAL_W      = 32;
  localparam int WL_W       = 7;
  localparam int ST_W       = 7;
  localparam int FS_W       = 9;
  localparam int PH_W       = 6;
  localparam int MAX_STRIDE = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Product of a Q4.12 weight and a Q.8 sum, and its rounded Q.8 form.
  localparam int FRAC_W   = 12;
  localparam int PROD_W   = COEF_W + SUM_W;
  localparam int RND_W    = PROD_W - FRAC_W;
  localparam int RND_EXT_W  = VAL_W - RND_W;
  localparam int BIAS_EXT_W = VAL_W - COEF_W;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_W - 1));

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE    = 2'd2;

  // Operation codes of an input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic [FRAME_W-1:0]       frame;
    logic                     last;
    logic signed [SUM_W-1:0]  sum;
    logic signed [COEF_W-1:0] weight;
    logic signed [COEF_W-1:0] bias;
  } tss_mac_req_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic [FRAME_W-1:0]      frame;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } tss_result_t;

endpackage

// File: hdl/tss_if.sv
// ----------------------------------------------------------------------------
// Temporal subsampling stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tss_in_if;
  import tss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [CH_W-1:0]          channel;
  logic signed [SAMP_W-1:0] sample;
  logic signed [COEF_W-1:0] weight_value;
  logic signed [COEF_W-1:0] bias_value;
  logic                     start_req;

  modport source (
    output valid, operation, channel, sample, weight_value, bias_value, start_req,
    input  ready
  );
  modport sink (
    input  valid, operation, channel, sample, weight_value, bias_value, start_req,
    output ready
  );
endinterface

interface tss_out_if;
  import tss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         out_channel;
  logic [FRAME_W-1:0]      out_frame;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (
    output valid, out_channel, out_frame, value, last,
    input  ready
  );
  modport sink (
    input  valid, out_channel, out_frame, value, last,
    output ready
  );
endinterface

// File: hdl/tss_mac.sv
// ----------------------------------------------------------------------------
// Temporal subsampling multiply-round unit
// Three registered stages: request, weight times sum, rounding plus bias into
// the output register.
// ----------------------------------------------------------------------------
module tss_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  tss_pkg::tss_mac_req_t req_i,
  output logic                 req_ready_o,
  output logic                 res_valid_o,
  output tss_pkg::tss_result_t res_o,
  input  logic                 res_ready_i
);
  import tss_pkg::*;

  logic                     m_v_q, p_v_q, o_v_q;
  logic                     go_m, go_p, go_o;
  tss_mac_req_t             m_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [COEF_W-1:0] p_bias_q;
  logic [CH_W-1:0]          p_ch_q;
  logic [FRAME_W-1:0]       p_frame_q;
  logic                     p_last_q;
  logic signed [PROD_W-1:0] rnd;
  logic signed [RND_W-1:0]  rnd_q8;
  logic signed [VAL_W-1:0]  value_d;
  tss_result_t              res_q;

  assign go_o        = !o_v_q || res_ready_i;
  assign go_p        = !p_v_q || go_o;
  assign go_m        = !m_v_q || go_p;
  assign req_ready_o = go_m;

  assign prod_d = $signed(m_q.weight) * $signed(m_q.sum);

  // Round half up, then floor shift; the biased result always fits in 32 bits,
  // so saturation can never engage.
  assign rnd     = prod_q + RND_HALF;
  assign rnd_q8  = rnd[PROD_W-1:FRAC_W];
  assign value_d = {{RND_EXT_W{rnd_q8[RND_W-1]}}, rnd_q8}
                 + {{BIAS_EXT_W{p_bias_q[COEF_W-1]}}, p_bias_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (go_m) m_v_q <= req_valid_i;
      if (go_p) p_v_q <= m_v_q;
      if (go_o) o_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_m) m_q <= req_i;
    if (go_p) begin
      prod_q    <= prod_d;
      p_bias_q  <= m_q.bias;
      p_ch_q    <= m_q.channel;
      p_frame_q <= m_q.frame;
      p_last_q  <= m_q.last;
    end
    if (go_o) begin
      res_q.channel <= p_ch_q;
      res_q.frame   <= p_frame_q;
      res_q.value   <= value_d;
      res_q.last    <= p_last_q;
    end
  end

  assign res_valid_o = o_v_q;
  assign res_o       = res_q;

endmodule

// File: hdl/temporal_subsampling_forward_top.sv
// ----------------------------------------------------------------------------
// Temporal subsampling forward, top level
// Strided window sums per channel, held in a history memory and a running-sum
// memory, scaled by per-channel weight and bias.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Carries
//  in_i      sink       valid/ready    operation, channel, sample, weight, bias
//  out_o     source     valid/ready    channel, output frame, value, last
//  cfg_*     input      write enable   window length, stride, frame size
//
//  One item per cycle sustained while the output is not stalled; a data item
//  passes memory read, running-sum write-back, multiply and round to the output.
//  The running-sum read-modify-write forwards the value just written when
//  two consecutive items touch the same channel, so nothing interlocks.
//  Reset needs no clearing pass: running sums and coefficients carry valid bits.
//  The history memory must be read only where written; the block does not
//  enforce this. A stalled output fills the stages behind it before intake stops.
// ----------------------------------------------------------------------------
module temporal_subsampling_forward_top #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tss_in_if.sink                           in_i,
  tss_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [tss_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tss_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tss_pkg::*;

  localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int HIST_DEPTH = MAX_WINDOW * NUM_CH;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam logic [FS_W-1:0] MAX_WIN_V = FS_W'(MAX_WINDOW);

  // Configuration, held already clamped to the legal ranges.
  logic [WL_W-1:0] wl_q;
  logic [ST_W-1:0] st_q;
  logic [FS_W-1:0] fs_q;
  logic [WL_W-1:0] cfg_d7;

  // Sequence counters.
  logic [WL_W-1:0]    seen_q, seen_d, seen_e;
  logic [PH_W-1:0]    ph_q, ph_d, ph_e;
  logic [PTR_W-1:0]   ptr_q, ptr_d, ptr_e;
  logic [FRAME_W-1:0] oidx_q, oidx_d, oidx_e;

  logic            accept, acc_data, acc_load, acc_keep, start;
  logic            ch_ok, is_last, full, emit, hsub;
  logic [CH_W-1:0] ch, last_ch;
  logic [HA_W-1:0] haddr;

  // Memories and their registered read data.
  logic signed [SAMP_W-1:0]         hist_mem [HIST_DEPTH];
  logic signed [SUM_W-1:0]          sum_mem  [NUM_CH];
  logic [2*COEF_W-1:0]              coef_mem [NUM_CH];
  logic [NUM_CH-1:0]                sum_vld_q, coef_vld_q;
  logic signed [SAMP_W-1:0]         hist_rd_q;
  logic signed [SUM_W-1:0]          sum_rd_q;
  logic [2*COEF_W-1:0]              coef_rd_q;
  logic                             coef_ok_q;

  // Write-back stage.
  logic                     v1_q, go1, wb;
  logic [CH_W-1:0]          s1_ch_q;
  logic [HA_W-1:0]          s1_haddr_q;
  logic signed [SAMP_W-1:0] s1_sample_q;
  logic                     s1_emit_q, s1_hsub_q, s1_last_q;
  logic [FRAME_W-1:0]       s1_frame_q;
  logic                     s1_sum_zero_q, s1_sum_fwd_q, s1_hist_fwd_q;
  logic signed [SUM_W-1:0]  fwd_sum_q;
  logic signed [SAMP_W-1:0] fwd_samp_q;
  logic signed [SUM_W-1:0]  old_sum, new_sum, hist_term;
  logic signed [SAMP_W-1:0] hist_val;

  tss_mac_req_t mac_req;
  tss_result_t  mac_res;
  logic         mac_ready, mac_valid;

  // --------------------------------------------------------------------------
  // Configuration writes.
  // --------------------------------------------------------------------------
  assign cfg_d7 = cfg_data_i[WL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WL_W'(1);
      st_q <= ST_W'(1);
      fs_q <= FS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_LENGTH: begin
          if (cfg_d7 == '0)                          wl_q <= WL_W'(1);
          else if ({2'b00, cfg_d7} > MAX_WIN_V)      wl_q <= MAX_WIN_V[WL_W-1:0];
          else                                       wl_q <= cfg_d7;
        end
        CFG_STRIDE: begin
          if (cfg_d7 == '0)                          st_q <= ST_W'(1);
          else if (cfg_d7 > ST_W'(MAX_STRIDE))       st_q <= ST_W'(MAX_STRIDE);
          else                                       st_q <= cfg_d7;
        end
        CFG_FRAME_SIZE: begin
          if (cfg_data_i == '0)                      fs_q <= FS_W'(1);
          else if (cfg_data_i > FS_W'(NUM_CH))       fs_q <= FS_W'(NUM_CH);
          else                                       fs_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Intake and sequence control.
  // --------------------------------------------------------------------------
  assign go1        = !s1_emit_q || mac_ready;
  assign wb         = v1_q && go1;
  assign in_i.ready = !v1_q || go1;

  assign accept   = in_i.valid && in_i.ready;
  assign acc_data = accept && (in_i.operation == OP_DATA);
  assign acc_load = accept && (in_i.operation == OP_LOAD);
  assign start    = in_i.start_req;
  assign ch       = in_i.channel;
  assign last_ch  = CH_W'(fs_q - FS_W'(1));
  assign ch_ok    = {1'b0, ch} < fs_q;
  assign is_last  = ch_ok && (ch == last_ch);
  assign acc_keep = acc_data && ch_ok;

  // A start request clears the counters before its own sample is counted.
  assign seen_e = start ? '0 : seen_q;
  assign ph_e   = start ? '0 : ph_q;
  assign ptr_e  = start ? '0 : ptr_q;
  assign oidx_e = start ? '0 : oidx_q;

  assign full  = ({1'b0, seen_e} + (WL_W + 1)'(1)) >= {1'b0, wl_q};
  assign emit  = full && (ph_e == '0);
  assign hsub  = seen_e >= wl_q;
  assign haddr = HA_W'({ptr_e, ch});

  always_comb begin
    seen_d = seen_q;
    ph_d   = ph_q;
    ptr_d  = ptr_q;
    oidx_d = oidx_q;
    if (acc_data) begin
      seen_d = seen_e;
      ph_d   = ph_e;
      ptr_d  = ptr_e;
      oidx_d = oidx_e;
      if (is_last) begin
        seen_d = (seen_e < wl_q) ? seen_e + WL_W'(1) : wl_q;
        ptr_d  = ((FS_W'(ptr_e) + FS_W'(1)) >= FS_W'(wl_q)) ? '0 : ptr_e + PTR_W'(1);
        if (full) begin
          if (emit) oidx_d = oidx_e + FRAME_W'(1);
          ph_d = ((ST_W'(ph_e) + ST_W'(1)) >= st_q) ? '0 : ph_e + PH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      ph_q   <= '0;
      ptr_q  <= '0;
      oidx_q <= '0;
    end else begin
      seen_q <= seen_d;
      ph_q   <= ph_d;
      ptr_q  <= ptr_d;
      oidx_q <= oidx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Memories: read on acceptance, written back when the item leaves the
  // write-back stage. Coefficients are written directly by load items.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (acc_keep) hist_rd_q <= hist_mem[haddr];
    if (wb)       hist_mem[s1_haddr_q] <= s1_sample_q;
  end

  always_ff @(posedge clk_i) begin
    if (acc_keep) sum_rd_q <= sum_mem[ch];
    if (wb)       sum_mem[s1_ch_q] <= new_sum;
  end

  always_ff @(posedge clk_i) begin
    if (acc_keep) coef_rd_q <= coef_mem[ch];
    if (acc_load) coef_mem[ch] <= {in_i.weight_value, in_i.bias_value};
  end

  // A start clears every running sum at once, including one written back in
  // the same cycle, since that item precedes the start in stream order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q  <= '0;
      coef_vld_q <= '0;
    end else begin
      if (acc_data && start) sum_vld_q <= '0;
      else if (wb)           sum_vld_q[s1_ch_q] <= 1'b1;
      if (acc_load)          coef_vld_q[ch] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Write-back stage.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (accept || go1) begin
      v1_q <= acc_keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_keep) begin
      s1_ch_q       <= ch;
      s1_haddr_q    <= haddr;
      s1_sample_q   <= in_i.sample;
      s1_emit_q     <= emit;
      s1_hsub_q     <= hsub;
      s1_last_q     <= is_last;
      s1_frame_q    <= oidx_e;
      coef_ok_q     <= coef_vld_q[ch];
      s1_sum_zero_q <= start || !sum_vld_q[ch];
      // The item leaving this stage writes at the same edge as this read.
      s1_sum_fwd_q  <= !start && wb && (s1_ch_q == ch);
      s1_hist_fwd_q <= wb && (s1_haddr_q == haddr);
      fwd_sum_q     <= new_sum;
      fwd_samp_q    <= s1_sample_q;
    end
  end

  always_comb begin
    if (s1_sum_fwd_q)       old_sum = fwd_sum_q;
    else if (s1_sum_zero_q) old_sum = '0;
    else                    old_sum = sum_rd_q;
    hist_val  = s1_hist_fwd_q ? fwd_samp_q : hist_rd_q;
    hist_term = s1_hsub_q ? {{SUM_EXT_W{hist_val[SAMP_W-1]}}, hist_val} : '0;
    new_sum   = old_sum + {{SUM_EXT_W{s1_sample_q[SAMP_W-1]}}, s1_sample_q} - hist_term;
  end

  assign mac_valid       = v1_q && s1_emit_q;
  assign mac_req.channel = s1_ch_q;
  assign mac_req.frame   = s1_frame_q;
  assign mac_req.last    = s1_last_q;
  assign mac_req.sum     = new_sum;
  assign mac_req.weight  = coef_ok_q ? coef_rd_q[2*COEF_W-1:COEF_W] : '0;
  assign mac_req.bias    = coef_ok_q ? coef_rd_q[COEF_W-1:0] : '0;

  tss_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (mac_valid),
    .req_i       (mac_req),
    .req_ready_o (mac_ready),
    .res_valid_o (out_o.valid),
    .res_o       (mac_res),
    .res_ready_i (out_o.ready)
  );

  assign out_o.out_channel = mac_res.channel;
  assign out_o.out_frame   = mac_res.frame;
  assign out_o.value       = mac_res.value;
  assign out_o.last        = mac_res.last;

`ifndef SYNTHESIS
  a_sum_forward : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_keep && wb && !start && (s1_ch_q == ch) |=> s1_sum_fwd_q)
    else $error("running sum not forwarded between same-channel items");

  a_sum_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb && !(acc_data && start) |=> sum_vld_q[$past(s1_ch_q)])
    else $error("written running sum not marked valid");

  a_start_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_data && start && !is_last |=> (seen_q == '0) && (oidx_q == '0) && (ph_q == '0))
    else $error("start request did not clear the sequence counters");

  a_last_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last == (out_o.out_channel == last_ch)))
    else $error("last flag does not match the final channel of the frame");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Temporal subsampling forward: block-level testbench
// Drives input items through a valid/ready channel under random bursts, gaps
// and output stalls. Each accepted item runs through a local model of the
// strided window sum, and every result item is checked against the oldest
// expected one. Covers register limits, restarts, ignored channels, running
// sum wrap-around and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tss_pkg::*;

  localparam int     HIST_DEPTH = 64;
  localparam longint VAL_MAX    = 64'sd2147483647;
  localparam longint VAL_MIN    = -64'sd2147483648;

  typedef struct {
    logic                     op;
    logic [CH_W-1:0]          channel;
    logic signed [SAMP_W-1:0] sample;
    logic signed [COEF_W-1:0] weight;
    logic signed [COEF_W-1:0] bias;
    logic                     start;
  } sub_item_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tss_in_if  in_if ();
  tss_out_if out_if ();

  temporal_subsampling_forward_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Local copy of the block state.
  bit signed [SAMP_W-1:0] hist_mem   [HIST_DEPTH][NUM_CH];
  bit                     hist_valid [HIST_DEPTH][NUM_CH];
  bit signed [SUM_W-1:0]  sum_mem    [NUM_CH];
  bit signed [COEF_W-1:0] weight_mem [NUM_CH];
  bit signed [COEF_W-1:0] bias_mem   [NUM_CH];
  int unsigned            frames_seen, stride_phase, hist_ptr;
  bit [FRAME_W-1:0]       frame_no;
  bit [WL_W-1:0]          reg_window = 1;
  bit [ST_W-1:0]          reg_stride = 1;
  bit [FS_W-1:0]          reg_frame  = 1;

  tss_result_t pending_outputs[$];

  int unsigned items_sent, loads_sent, starts_sent, results_seen, settings_used;
  int unsigned errors, reported;
  int unsigned burst_left, hold_request, hold_left, rx_mode, rx_mode_left, rx_cycle;
  bit          steady_send, hold_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // A history entry that was never written must not be read; such an item is
  // turned into a sequence start, which cannot read the history at all.
  function automatic bit reads_unwritten(input sub_item_t it);
    int unsigned wl, fs;
    wl = clamp_reg(reg_window, HIST_DEPTH);
    fs = clamp_reg(reg_frame, NUM_CH);
    return it.op == OP_DATA && !it.start && it.channel < fs && frames_seen >= wl &&
           !hist_valid[hist_ptr][it.channel];
  endfunction

  function automatic void predict_window_sum(input sub_item_t it);
    int unsigned           wl, st, fs, ptr;
    longint                acc, prod, res;
    bit signed [SUM_W-1:0] new_sum;
    bit                    full, emit;
    tss_result_t           r;
    wl = clamp_reg(reg_window, HIST_DEPTH);
    st = clamp_reg(reg_stride, MAX_STRIDE);
    fs = clamp_reg(reg_frame, NUM_CH);
    if (it.op == OP_LOAD) begin
      weight_mem[it.channel] = it.weight;
      bias_mem[it.channel]   = it.bias;
      return;
    end
    ptr = hist_ptr;
    if (it.start) begin
      foreach (sum_mem[i]) sum_mem[i] = '0;
      frames_seen  = 0;
      stride_phase = 0;
      hist_ptr     = 0;
      frame_no     = '0;
      ptr          = 0;
    end
    if (it.channel >= fs) return;

    acc = longint'(sum_mem[it.channel]) + longint'(it.sample);
    if (frames_seen >= wl) acc -= longint'(hist_mem[ptr][it.channel]);
    new_sum = SUM_W'(acc);
    sum_mem[it.channel]        = new_sum;
    hist_mem[ptr][it.channel]  = it.sample;
    hist_valid[ptr][it.channel] = 1'b1;

    full = (frames_seen + 1) >= wl;
    emit = full && stride_phase == 0;
    if (emit) begin
      // Q4.12 times Q.8, rounded half up back to Q.8, then the bias.
      prod = longint'(weight_mem[it.channel]) * longint'(new_sum) + 2048;
      res  = (prod >>> FRAC_W) + longint'(bias_mem[it.channel]);
      if (res > VAL_MAX) res = VAL_MAX;
      else if (res < VAL_MIN) res = VAL_MIN;
      r.channel = it.channel;
      r.frame   = frame_no;
      r.value   = VAL_W'(res);
      r.last    = (it.channel == fs - 1);
      pending_outputs.push_back(r);
    end

    if (it.channel == fs - 1) begin
      frames_seen = (frames_seen < wl) ? frames_seen + 1 : wl;
      hist_ptr    = (ptr + 1 >= wl) ? 0 : ptr + 1;
      if (full) begin
        if (emit) frame_no++;
        stride_phase = (stride_phase + 1 >= st) ? 0 : stride_phase + 1;
      end
    end
  endfunction

  task automatic offer_item(inout sub_item_t it);
    int unsigned gap;
    if (reads_unwritten(it)) it.start = 1'b1;
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= it.op;
    in_if.channel      <= it.channel;
    in_if.sample       <= it.sample;
    in_if.weight_value <= it.weight;
    in_if.bias_value   <= it.bias;
    in_if.start_req    <= it.start;
    do begin
      @(posedge clk_i);
    end while (in_if.ready !== 1'b1);
    predict_window_sum(it);
    items_sent++;
    if (it.op == OP_LOAD) loads_sent++;
    else if (it.start) starts_sent++;
  endtask

  task automatic send_data(input logic [CH_W-1:0] ch, input logic [SAMP_W-1:0] s,
                           input bit start);
    sub_item_t it;
    it.op      = OP_DATA;
    it.channel = ch;
    it.sample  = s;
    it.weight  = rand_word();
    it.bias    = rand_word();
    it.start   = start;
    offer_item(it);
  endtask

  task automatic send_load(input logic [CH_W-1:0] ch, input logic [COEF_W-1:0] w,
                           input logic [COEF_W-1:0] b, input bit start);
    sub_item_t it;
    it.op      = OP_LOAD;
    it.channel = ch;
    it.sample  = rand_word();
    it.weight  = w;
    it.bias    = b;
    it.start   = start;
    offer_item(it);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    // An item that yields nothing may still be in the pipeline.
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned wl, input int unsigned st,
                            input int unsigned fs);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WINDOW_LENGTH;
    cfg_data_i <= CFG_DATA_W'(wl);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_STRIDE;
    cfg_data_i <= CFG_DATA_W'(st);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FRAME_SIZE;
    cfg_data_i <= CFG_DATA_W'(fs);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    reg_window = WL_W'(wl);
    reg_stride = ST_W'(st);
    reg_frame  = FS_W'(fs);
    settings_used++;
  endtask

  // Mostly whole frames in channel order with random content; the rest are
  // coefficient loads, channels outside the frame, repeated channels and,
  // where allowed, restarts in the middle of a frame.
  task automatic run_stream(input int n, input bit restarts);
    sub_item_t   it;
    int unsigned fs, pick, next_ch;
    bit          well;
    fs      = clamp_reg(reg_frame, NUM_CH);
    next_ch = 0;
    for (int i = 0; i < n; i++) begin
      it.op      = OP_DATA;
      it.channel = CH_W'(next_ch);
      it.sample  = rand_word();
      it.weight  = rand_word();
      it.bias    = rand_word();
      it.start   = 1'b0;
      well       = 1'b0;
      pick       = $urandom_range(99);
      if (i == 0 || (restarts && pick < 2)) begin
        it.start   = 1'b1;
        it.channel = '0;
      end else if (restarts && pick < 5) begin
        it.start   = 1'b1;
        it.channel = CH_W'($urandom_range(fs - 1));
      end else if (pick >= 5 && pick < 12) begin
        it.op      = OP_LOAD;
        it.channel = CH_W'($urandom);
        it.start   = 1'($urandom);
      end else if (pick >= 12 && pick < 15 && fs < NUM_CH) begin
        it.channel = CH_W'($urandom_range(NUM_CH - 1, fs));
      end else if (pick >= 12 && pick < 18) begin
        it.channel = CH_W'($urandom_range(fs - 1));
      end else begin
        well = 1'b1;
      end
      offer_item(it);
      if (it.op == OP_DATA && it.channel < fs && (it.start || well))
        next_ch = (it.channel + 1 >= fs) ? 0 : it.channel + 1;
    end
  endtask

  task automatic test_directed();
    // Registers at their reset values: one channel per frame, window of one.
    send_data(8'd0, 16'h7FFF, 1'b1);
    send_data(8'd0, 16'h8000, 1'b0);
    send_data(8'd1, 16'h0123, 1'b0);
    drain_results();
    set_config(2, 1, 2);
    send_load(8'd0, 16'h7FFF, 16'h7FFF, 1'b0);
    send_load(8'd1, 16'h8000, 16'h8000, 1'b0);
    send_load(8'd255, 16'h1234, 16'h00FF, 1'b1);  // start flag on a load does nothing
    send_data(8'd0, 16'h7FFF, 1'b1);
    send_data(8'd200, 16'h5555, 1'b0);            // outside the frame, ignored
    send_data(8'd1, 16'h8000, 1'b0);
    send_data(8'd0, 16'h7FFF, 1'b0);
    send_data(8'd1, 16'h8000, 1'b0);
    send_data(8'd0, 16'h7FFF, 1'b0);
    send_data(8'd1, 16'h8000, 1'b0);
    send_data(8'd0, 16'hFFFF, 1'b0);
    send_data(8'd1, 16'h0001, 1'b0);
    send_load(8'd0, 16'h1000, 16'h0000, 1'b0);
    send_data(8'd0, 16'h0100, 1'b0);
    send_data(8'd1, 16'h0100, 1'b0);
    send_data(8'd1, 16'h0005, 1'b1);              // restart on the last channel
    send_data(8'd0, 16'h0200, 1'b0);
    send_data(8'd1, 16'h0300, 1'b0);
    send_data(8'd0, 16'h0000, 1'b0);
    send_data(8'd1, 16'h0000, 1'b0);
  endtask

  task automatic test_register_limits();
    drain_results();
    set_config(0, 0, 0);
    run_stream(50, 1'b1);
    drain_results();
    set_config(127, 127, 1);
    run_stream(150, 1'b0);
    drain_results();
    set_config(1, 2, 511);
    run_stream(260, 1'b0);
  endtask

  task automatic test_window_stride();
    drain_results();
    set_config(3, 2, 4);
    run_stream(80, 1'b1);
    drain_results();
    set_config(64, 1, 2);
    run_stream(160, 1'b0);
    drain_results();
    set_config(1, 64, 1);
    run_stream(130, 1'b0);
    drain_results();
    set_config(5, 3, 6);
    run_stream(80, 1'b1);
  endtask

  // Repeating a channel before its frame ends piles samples into one sum
  // until the 22-bit sum wraps, once upwards and once downwards.
  task automatic test_sum_wrap();
    drain_results();
    set_config(1, 1, 2);
    send_load(8'd0, 16'h1000, 16'h0000, 1'b0);
    for (int i = 0; i < 70; i++) send_data(8'd0, 16'h7FFF, i == 0);
    send_data(8'd1, 16'h0001, 1'b0);
    for (int i = 0; i < 70; i++) send_data(8'd0, 16'h8000, i == 0);
    send_data(8'd1, 16'h0001, 1'b0);
  endtask

  task automatic test_output_stall();
    drain_results();
    set_config(2, 1, 4);
    steady_send  = 1'b1;
    hold_request = 300;
    run_stream(60, 1'b1);
    steady_send  = 1'b0;
    drain_results();
    run_stream(40, 1'b1);
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      drain_results();
      set_config($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 12));
      run_stream(30, 1'b1);
    end
  endtask

  // Result side: checks every accepted result item and picks the ready
  // pattern for the next cycle.
  always @(posedge clk_i) begin : result_side
    tss_result_t got, want;
    bit          bad;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.channel = out_if.out_channel;
      got.frame   = out_if.out_frame;
      got.value   = out_if.value;
      got.last    = out_if.last;
      if (pending_outputs.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("tb: result with none expected: ch %0d frame %0d value %0d last %0b",
                   got.channel, got.frame, got.value, got.last);
        end
      end else begin
        want = pending_outputs.pop_front();
        results_seen++;
        bad = (got.channel !== want.channel) || (got.frame !== want.frame) ||
              (got.value !== want.value) || (got.last !== want.last);
        if (bad) begin
          errors++;
          if (reported < 10) begin
            reported++;
            $display("tb: mismatch at %0t: expected ch %0d frame %0d value %0d last %0b",
                     $realtime, want.channel, want.frame, want.value, want.last);
            $display("tb:                  got ch %0d frame %0d value %0d last %0b",
                     got.channel, got.frame, got.value, got.last);
          end
        end
      end
    end
    if (hold_request != 0 && !hold_taken) begin
      hold_left  = hold_request;
      hold_taken = 1'b1;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(3);
      rx_mode_left = $urandom_range(32, 400);
    end
    rx_mode_left--;
    rx_cycle++;
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom);
        2:       out_if.ready <= ($urandom_range(3) == 0);
        default: out_if.ready <= (rx_cycle % 8) < 5;
      endcase
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_DATA;
    in_if.channel      = '0;
    in_if.sample       = '0;
    in_if.weight_value = '0;
    in_if.bias_value   = '0;
    in_if.start_req    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_limits();
    test_window_stride();
    test_sum_wrap();
    test_output_stall();
    test_random_settings();
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("tb: %0d items sent (%0d coefficient loads, %0d sequence starts) over %0d settings",
             items_sent, loads_sent, starts_sent, settings_used);
    $display("tb: %0d results checked, %0d failures", results_seen, errors);
    if (errors == 0 && pending_outputs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
